// File: sv/vdlp_pkg.sv
// vdlp_pkg: types and constants for the vector display list processor.
// No dependencies.
`timescale 1ns / 1ps
package vdlp_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [3:0] OPC_LABS = 4'hA;
  localparam logic [3:0] OPC_HALT = 4'hB;
  localparam logic [3:0] OPC_JSRL = 4'hC;
  localparam logic [3:0] OPC_RTSL = 4'hD;
  localparam logic [3:0] OPC_JMPL = 4'hE;
  localparam logic [3:0] OPC_SVEC = 4'hF;

  localparam logic [15:0] Y_FLIP = 16'd1023;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [15:0] data;
  } item_t;

  typedef struct packed {
    logic        draw_valid;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [3:0]  brightness;
    logic        running;
    logic [1:0]  status;
    logic [11:0] next_pc;
  } result_t;

  // Delta scaling: shift is signed, positive means right.
  function automatic logic [15:0] scaled_delta(logic [9:0] mag, logic signed [6:0] sh,
                                               logic neg);
    logic [15:0] r;
    logic [15:0] m;
    m = {6'd0, mag};
    if (!sh[6]) r = (sh >= 7'sd16) ? 16'd0 : (m >> sh[3:0]);
    else        r = m << 5'((-sh) & 7'sd31);
    return neg ? 16'(0 - r) : r;
  endfunction

  function automatic logic [15:0] labs_coord(logic [15:0] w);
    return w[10] ? 16'({6'd0, w[9:0]} - 16'd1024) : {6'd0, w[9:0]};
  endfunction

endpackage

// File: sv/vdlp_if.sv
// vdlp_if: valid/ready channel carrying one beat of a payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface vdlp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/vdlp_ram.sv
// vdlp_ram: generic single-port-write, single-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module vdlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: sv/vdlp_front.sv
// vdlp_front: accepts input beats into a two-entry queue.
// Depends on vdlp_pkg.
`timescale 1ns / 1ps
module vdlp_front import vdlp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);
  item_t       buf_q [2];
  logic        rd_q, wr_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, q_pop_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_item_i;
  end
endmodule

// File: sv/vdlp_back.sv
// vdlp_back: executes queued items against the list memory and beam state.
// Depends on vdlp_pkg and vdlp_ram.
`timescale 1ns / 1ps
module vdlp_back import vdlp_pkg::*; #(
  parameter int MEM_WORDS   = 4096,
  parameter int STACK_DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  output logic    q_pop_o,
  input  item_t   q_item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_RD1  = 3'd3;
  localparam logic [2:0] S_EXE2 = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [11:0] pc_q;
  logic [15:0] bx_q, by_q;
  logic signed [5:0] gsh_q;
  logic [11:0] stk_q [STACK_DEPTH];
  logic [SW-1:0] dep_q;
  logic        run_q;
  logic [15:0] w0_q;
  logic        out_full_q;
  result_t     out_q;

  logic        we;
  logic [AW-1:0] raddr;
  logic [15:0] rdata;
  logic        idle_take;

  // Idle state takes the queue head once the result register is free at this edge
  assign idle_take = q_valid_i && state_q == S_IDLE && (!out_full_q || res_ready_i);
  assign we = idle_take && q_item_i.operation == OP_WRITE
              && ({4'd0, q_item_i.address} < 16'(MEM_WORDS));
  assign raddr = pc_q[AW-1:0];

  vdlp_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(q_item_i.address[AW-1:0]), .wdata_i(q_item_i.data),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign res_valid_o = out_full_q;
  assign res_o       = out_q;

  // Move helper values
  logic [3:0]  opc;
  logic signed [6:0] vsh, ssh;
  logic [1:0]  sc;
  logic [15:0] dx, dy, nx, ny;
  logic [3:0]  z;
  logic [11:0] pc_inc;
  logic        multi_word;
  assign opc    = w0_q[15:12];
  assign pc_inc = pc_q + 12'd1;
  assign sc     = {w0_q[3], w0_q[11]};
  assign ssh    = 7'(gsh_q) + 7'(7 - {5'd0, sc});
  assign vsh    = 7'(gsh_q) + 7'(9 - {3'd0, opc});
  assign multi_word = (opc <= 4'd9) || (opc == OPC_LABS);

  always_comb begin
    if (state_q == S_EXE2) begin
      dx = scaled_delta(rdata[9:0], vsh, rdata[10]);
      dy = scaled_delta(w0_q[9:0], vsh, w0_q[10]);
      z  = rdata[15:12];
    end else begin
      dx = scaled_delta({w0_q[1:0], 8'd0}, ssh, w0_q[2]);
      dy = scaled_delta({w0_q[9:8], 8'd0}, ssh, w0_q[10]);
      z  = w0_q[7:4];
    end
    nx = bx_q + dx;
    ny = by_q + dy;
  end

  // Item ends: non-execute items and executes while not running in idle, one-word opcodes in RD1, two-word in EXE2
  assign q_pop_o = (idle_take && !(q_item_i.operation == OP_EXEC && run_q))
                   || (state_q == S_RD1 && !multi_word) || (state_q == S_EXE2);

  // Result of the item that ends this cycle
  result_t r;
  always_comb begin
    r = '0;
    r.running = run_q;
    r.next_pc = pc_q;
    unique case (state_q)
      S_IDLE: if (q_item_i.operation == OP_START) begin
        r.running = 1'b1; r.next_pc = '0;
      end
      S_RD1: begin
        case (opc)
          OPC_SVEC: if (z != 4'd0) begin
            r.draw_valid = 1'b1; r.x_start = bx_q; r.y_start = Y_FLIP - by_q;
            r.x_end = nx; r.y_end = Y_FLIP - ny; r.brightness = z;
          end
          OPC_HALT: r.running = 1'b0;
          OPC_JSRL: if (32'(dep_q) >= STACK_DEPTH) begin
            r.running = 1'b0; r.status = ST_OVERFLOW;
          end else begin
            r.next_pc = w0_q[11:0];
          end
          OPC_RTSL: if (dep_q == '0) begin
            r.running = 1'b0; r.status = ST_UNDERFLOW;
          end else begin
            r.next_pc = stk_q[IW'(dep_q - 1'b1)];
          end
          OPC_JMPL: r.next_pc = w0_q[11:0];
          default: ;
        endcase
      end
      S_EXE2: if (opc != OPC_LABS && z != 4'd0) begin
        r.draw_valid = 1'b1; r.x_start = bx_q; r.y_start = Y_FLIP - by_q;
        r.x_end = nx; r.y_end = Y_FLIP - ny; r.brightness = z;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pc_q <= '0; bx_q <= '0; by_q <= '0; gsh_q <= '0;
      dep_q <= '0; run_q <= 1'b0; out_full_q <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
    end else begin
      if (res_ready_i) out_full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (idle_take) begin
          if (q_item_i.operation == OP_START) begin
            pc_q <= '0; bx_q <= '0; by_q <= '0; gsh_q <= '0; dep_q <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
            run_q <= 1'b1;
          end else if (q_item_i.operation == OP_EXEC && run_q) begin
            state_q <= S_RD0;
          end
        end
        S_RD0: begin
          state_q <= S_DEC;
          pc_q <= pc_inc;
        end
        S_DEC: begin
          w0_q <= rdata;
          state_q <= S_RD1;
        end
        S_RD1: begin
          if (multi_word) begin
            pc_q <= pc_inc;
            state_q <= S_EXE2;
          end else begin
            state_q <= S_IDLE;
            case (opc)
              OPC_SVEC: begin
                bx_q <= nx; by_q <= ny;
              end
              OPC_HALT: run_q <= 1'b0;
              OPC_JSRL: if (32'(dep_q) >= STACK_DEPTH) begin
                run_q <= 1'b0;
              end else begin
                stk_q[dep_q[IW-1:0]] <= pc_q;
                dep_q <= dep_q + 1'b1;
                pc_q <= w0_q[11:0];
              end
              OPC_RTSL: if (dep_q == '0) begin
                run_q <= 1'b0;
              end else begin
                dep_q <= dep_q - 1'b1;
                pc_q <= stk_q[IW'(dep_q - 1'b1)];
              end
              default: pc_q <= w0_q[11:0];
            endcase
          end
        end
        S_EXE2: begin
          state_q <= S_IDLE;
          if (opc == OPC_LABS) begin
            bx_q <= labs_coord(rdata);
            by_q <= labs_coord(w0_q);
            gsh_q <= rdata[15] ? 6'(16 - {2'd0, rdata[15:12]}) : -6'({2'd0, rdata[15:12]});
          end else begin
            bx_q <= nx; by_q <= ny;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (q_pop_o) begin
        out_full_q <= 1'b1;
        out_q <= r;
      end
    end
  end
endmodule

// File: sv/vector_display_list_processor.sv
// vector_display_list_processor: top level of the vector display list processor.
// Depends on vdlp_pkg, vdlp_if, vdlp_front, vdlp_back, vdlp_ram.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries item beats (operation, address, data); out_ch carries one
//   result beat per item, in order. An item is taken when valid and ready
//   are both high.
//   A front queue of two entries takes beats while the back end works, so the
//   sender stalls only when that queue is full.
//   Item steps: writes, starts and idle executes end in the idle state of the
//   back end; HALT, JSRL, RTSL, JMPL and SVEC step through RD0, DEC and RD1,
//   and VCTR and LABS go on to EXE2, set by the registered read of the list
//   memory (one word fetch per step).
//   Reset clears the beam, stack, program counter and run flag; the list
//   memory keeps its contents and must be written before it is executed.
//   When the receiver stalls, the result register holds and the back end
//   waits; the front queue keeps taking beats until it fills.
//   Stack overflow or underflow reports status and stops the run.
module vector_display_list_processor import vdlp_pkg::*; #(
  parameter int MEM_WORDS   = 4096,
  parameter int STACK_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  vdlp_if.sink   in_ch,
  vdlp_if.source out_ch
);
  logic  q_valid, q_pop;
  item_t q_item;

  vdlp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_item_i(in_ch.payload),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  vdlp_back #(.MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .res_valid_o(out_ch.valid), .res_ready_i(out_ch.ready), .res_o(out_ch.payload)
  );
endmodule

// File: sv/vdlp_checker.sv
// vdlp_checker: port-level assertions for the vector display list processor.
// Depends on vdlp_pkg, vdlp_if; bound to the top level.
`timescale 1ns / 1ps
module vdlp_checker import vdlp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid, out_ready,
  input result_t out_p
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_p)) else $error("result changed");
  a_nodraw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_p.draw_valid |-> out_p.brightness == 4'd0 && out_p.x_end == 16'd0)
    else $error("fields set without draw");
  a_draw_bright: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_p.draw_valid |-> out_p.brightness != 4'd0 && out_p.running)
    else $error("draw with zero brightness");
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_p.status != ST_OK |-> !out_p.running) else $error("error but running");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_p.status != 2'd3) else $error("bad status");
endmodule

bind vector_display_list_processor vdlp_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_p(out_ch.payload)
);
